// ===== rtl/core/kol_pkg.sv =====
// shared types, codes and keyword table of the keyword and operator lexer
package kol_pkg;

    // scanner mode between items
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_GT    = 3'd3,
        MODE_LT    = 3'd4,
        MODE_EQ    = 3'd5
    } t_mode;

    // load request from the scanner to the result queue
    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } t_load;

    // token codes
    localparam logic [4:0] TOK_END      = 5'd0;
    localparam logic [4:0] TOK_KW_FIRST = 5'd1;
    localparam logic [4:0] TOK_IDENT    = 5'd10;
    localparam logic [4:0] TOK_NUMBER   = 5'd11;
    localparam logic [4:0] TOK_GE       = 5'd12;
    localparam logic [4:0] TOK_GT       = 5'd13;
    localparam logic [4:0] TOK_LE       = 5'd14;
    localparam logic [4:0] TOK_NE       = 5'd15;
    localparam logic [4:0] TOK_LT       = 5'd16;
    localparam logic [4:0] TOK_EQEQ     = 5'd17;
    localparam logic [4:0] TOK_EQ       = 5'd18;
    localparam logic [4:0] TOK_COMMA    = 5'd19;
    localparam logic [4:0] TOK_SEMI     = 5'd20;
    localparam logic [4:0] TOK_LPAREN   = 5'd21;
    localparam logic [4:0] TOK_RPAREN   = 5'd22;
    localparam logic [4:0] TOK_PLUS     = 5'd23;
    localparam logic [4:0] TOK_MINUS    = 5'd24;
    localparam logic [4:0] TOK_STAR     = 5'd25;
    localparam logic [4:0] TOK_SLASH    = 5'd26;
    localparam logic [4:0] TOK_INVALID  = 5'd27;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // identifier characters kept for keyword matching
    localparam int PREFIX_LEN = 5;
    localparam int KW_COUNT   = 9;

    // keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [KW_COUNT][PREFIX_LEN] = '{
        '{8'h43, 8'h6F, 8'h6E, 8'h73, 8'h74},  // Const
        '{8'h56, 8'h61, 8'h72, 8'h00, 8'h00},  // Var
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},  // if
        '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00},  // then
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},  // else
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},  // while
        '{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00},  // do
        '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E},  // begin
        '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00}   // end
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd5, 3'd3
    };

    // keyword code of an identifier, identifier code when none matches
    function automatic logic [4:0] keyword_code(input logic [PREFIX_LEN-1:0][7:0] pfx,
                                                input logic [2:0] len);
        logic [4:0] code;
        logic       hit;
        code = TOK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == KW_LEN[k]);
            for (int j = 0; j < PREFIX_LEN; j++) begin
                if ((3'(j) < KW_LEN[k]) && (pfx[j] != KW_TEXT[k][j])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                code = TOK_KW_FIRST + 5'(k);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/kol_scan.sv =====
// scanner state and token generation for one character item
module kol_scan
    import kol_pkg::*;
#(
    parameter int VALUE_BITS  = 32,
    parameter int LENGTH_BITS = 8,
    parameter int TOK_W       = 5 + LENGTH_BITS + VALUE_BITS + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_is_final,
    output t_load                       o_load,
    output logic [2:0][TOK_W-1:0]       o_tok
);

    typedef struct packed {
        logic [4:0]             code;
        logic [LENGTH_BITS-1:0] len;
        logic [VALUE_BITS-1:0]  val;
        logic                   ovf;
    } t_tok;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    t_mode                           r_mode, n_mode;
    logic [LENGTH_BITS-1:0]          r_len, n_len;
    logic [VALUE_BITS-1:0]           r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic [PREFIX_LEN-1:0][7:0]      r_prefix, n_prefix;

    t_tok [2:0]                      toks;
    logic [1:0]                      cnt;
    logic                            done;
    logic                            is_letter, is_digit;
    logic [LENGTH_BITS-1:0]          len_inc;
    logic [VALUE_BITS+3:0]           acc_sum;
    logic                            acc_sat;

    function automatic t_tok mk(input logic [4:0] code, input logic [LENGTH_BITS-1:0] len,
                                input logic [VALUE_BITS-1:0] val, input logic ovf);
        t_tok t;
        t.code = code;
        t.len  = len;
        t.val  = val;
        t.ovf  = ovf;
        return t;
    endfunction

    // length as a keyword candidate, zero when it does not fit in three bits
    function automatic logic [2:0] short_len(input logic [LENGTH_BITS-1:0] len);
        return (|len[LENGTH_BITS-1:3]) ? 3'd0 : len[2:0];
    endfunction

    // character classes and counters
    assign is_letter = ((i_char_code >= CH_LA) && (i_char_code <= CH_LZ)) ||
                       ((i_char_code >= CH_UA) && (i_char_code <= CH_UZ));
    assign is_digit  = (i_char_code >= CH_0) && (i_char_code <= CH_9);
    assign len_inc   = (r_len == LEN_MAX) ? r_len : r_len + 1'b1;

    // saturating decimal accumulate: acc * 10 + digit
    assign acc_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} +
                     (VALUE_BITS+4)'(i_char_code[3:0]);
    assign acc_sat = |acc_sum[VALUE_BITS+3:VALUE_BITS];

    // token generation and next state
    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_prefix = r_prefix;
        toks     = '0;
        cnt      = 2'd0;
        done     = 1'b0;

        // continue the pending token
        unique case (r_mode)
            MODE_IDENT: begin
                if (is_letter || is_digit) begin
                    if (r_len < LENGTH_BITS'(PREFIX_LEN)) begin
                        n_prefix[r_len[2:0]] = i_char_code;
                    end
                    n_len = len_inc;
                    done  = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit) begin
                    n_acc = acc_sat ? '1 : acc_sum[VALUE_BITS-1:0];
                    n_ovf = r_ovf | acc_sat;
                    n_len = len_inc;
                    done  = 1'b1;
                end
            end
            MODE_GT: begin
                if (i_char_code == CH_EQ) begin
                    toks[cnt] = mk(TOK_GE, LENGTH_BITS'(2), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                    n_mode    = MODE_IDLE;
                    done      = 1'b1;
                end
            end
            MODE_LT: begin
                if (i_char_code == CH_EQ) begin
                    toks[cnt] = mk(TOK_LE, LENGTH_BITS'(2), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                    n_mode    = MODE_IDLE;
                    done      = 1'b1;
                end else if (i_char_code == CH_GT) begin
                    toks[cnt] = mk(TOK_NE, LENGTH_BITS'(2), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                    n_mode    = MODE_IDLE;
                    done      = 1'b1;
                end
            end
            MODE_EQ: begin
                if (i_char_code == CH_EQ) begin
                    toks[cnt] = mk(TOK_EQEQ, LENGTH_BITS'(2), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                    n_mode    = MODE_IDLE;
                    done      = 1'b1;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        // the character ends the pending token and starts its own
        if (!done) begin
            unique case (r_mode)
                MODE_IDENT: begin
                    toks[cnt] = mk(keyword_code(r_prefix, short_len(r_len)), r_len, '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_NUM: begin
                    toks[cnt] = mk(TOK_NUMBER, r_len, r_acc, r_ovf);
                    cnt       = cnt + 2'd1;
                end
                MODE_GT: begin
                    toks[cnt] = mk(TOK_GT, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_LT: begin
                    toks[cnt] = mk(TOK_LT, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_EQ: begin
                    toks[cnt] = mk(TOK_EQ, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            n_mode = MODE_IDLE;

            if ((i_char_code == CH_SPACE) || (i_char_code == CH_NL)) begin
                // separator, nothing to start
            end else if (is_letter) begin
                n_mode      = MODE_IDENT;
                n_prefix[0] = i_char_code;
                n_len       = LENGTH_BITS'(1);
            end else if (is_digit) begin
                n_mode = MODE_NUM;
                n_acc  = VALUE_BITS'(i_char_code[3:0]);
                n_ovf  = 1'b0;
                n_len  = LENGTH_BITS'(1);
            end else begin
                unique case (i_char_code)
                    CH_GT:     n_mode = MODE_GT;
                    CH_LT:     n_mode = MODE_LT;
                    CH_EQ:     n_mode = MODE_EQ;
                    CH_COMMA:  toks[cnt] = mk(TOK_COMMA,   LENGTH_BITS'(1), '0, 1'b0);
                    CH_SEMI:   toks[cnt] = mk(TOK_SEMI,    LENGTH_BITS'(1), '0, 1'b0);
                    CH_LPAREN: toks[cnt] = mk(TOK_LPAREN,  LENGTH_BITS'(1), '0, 1'b0);
                    CH_RPAREN: toks[cnt] = mk(TOK_RPAREN,  LENGTH_BITS'(1), '0, 1'b0);
                    CH_PLUS:   toks[cnt] = mk(TOK_PLUS,    LENGTH_BITS'(1), '0, 1'b0);
                    CH_MINUS:  toks[cnt] = mk(TOK_MINUS,   LENGTH_BITS'(1), '0, 1'b0);
                    CH_STAR:   toks[cnt] = mk(TOK_STAR,    LENGTH_BITS'(1), '0, 1'b0);
                    CH_SLASH:  toks[cnt] = mk(TOK_SLASH,   LENGTH_BITS'(1), '0, 1'b0);
                    default:   toks[cnt] = mk(TOK_INVALID, LENGTH_BITS'(1), '0, 1'b0);
                endcase
                if ((i_char_code != CH_GT) && (i_char_code != CH_LT) &&
                    (i_char_code != CH_EQ)) begin
                    cnt = cnt + 2'd1;
                end
            end
        end

        // last character: flush what is pending, add the end token, clear state
        if (i_is_final) begin
            unique case (n_mode)
                MODE_IDENT: begin
                    toks[cnt] = mk(keyword_code(n_prefix, short_len(n_len)), n_len, '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_NUM: begin
                    toks[cnt] = mk(TOK_NUMBER, n_len, n_acc, n_ovf);
                    cnt       = cnt + 2'd1;
                end
                MODE_GT: begin
                    toks[cnt] = mk(TOK_GT, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_LT: begin
                    toks[cnt] = mk(TOK_LT, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                MODE_EQ: begin
                    toks[cnt] = mk(TOK_EQ, LENGTH_BITS'(1), '0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            toks[cnt] = mk(TOK_END, '0, '0, 1'b0);
            cnt       = cnt + 2'd1;
            n_mode    = MODE_IDLE;
            n_len     = '0;
            n_acc     = '0;
            n_ovf     = 1'b0;
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    // identifier prefix, only read after being written
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prefix <= n_prefix;
        end
    end

    // tokens of this item to the result queue
    always_comb begin
        o_load.load  = i_accept;
        o_load.count = cnt;
        for (int i = 0; i < 3; i++) begin
            o_tok[i] = toks[i];
        end
    end

    // the last character leaves the scanner cleared
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_is_final |=> (r_mode == MODE_IDLE) && (r_len == '0))
        else $error("state not cleared after last character");

    // the last character always yields at least the end token
    a_final_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_is_final |-> (cnt != 2'd0))
        else $error("last character produced no token");

    // a number in progress holds at least one digit
    a_num_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUM) |-> (r_len != '0))
        else $error("number mode with zero length");

endmodule

// ===== rtl/core/kol_outq.sv =====
// result queue holding the tokens of one item and sending them one per cycle while not stalled
module kol_outq
    import kol_pkg::*;
#(
    parameter int W = 46
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_load               i_load,
    input  logic [2:0][W-1:0]   i_data,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [W-1:0]        o_data,
    output logic                o_last
);

    logic [1:0]          r_cnt;
    logic [2:0][W-1:0]   r_slot;
    logic                take;

    // handshake on the result side
    assign take       = o_valid && !i_stall;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && take);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_last     = (r_cnt == 2'd1);
    assign o_data     = r_slot[0];

    // token count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load.load) begin
            r_cnt <= i_load.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // token slots, shifted toward the head as tokens leave
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_slot <= i_data;
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    // a new item only loads once the previous one is drained
    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> o_can_load)
        else $error("item loaded over undelivered tokens");

    // each delivered token removes exactly one from the count
    a_take_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !i_load.load |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("token count did not step down");

    // a stalled queue keeps its count
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> (r_cnt == $past(r_cnt)))
        else $error("token count changed under stall");

endmodule

// ===== rtl/core/keyword_operator_lexer.sv =====
// Top level of the streaming keyword and operator lexer.
// Output: tokens of an item appear in the cycle after it is accepted, one token per cycle
// while i_stall is low. Input: one item per cycle while items yield at most one token and
// i_stall is low; an item that yields more (up to three) holds the input until its last token is taken.
// Reset: synchronous active-low i_rst_n clears scanner mode, counters and the result queue.
module keyword_operator_lexer
    import kol_pkg::*;
#(
    parameter int VALUE_BITS  = 32,
    parameter int LENGTH_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_char_code,
    input  logic                    i_is_final,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [4:0]              o_token_code,
    output logic [LENGTH_BITS-1:0]  o_lexeme_length,
    output logic [VALUE_BITS-1:0]   o_number_value,
    output logic                    o_number_overflow,
    output logic                    o_run_last
);

    localparam int TOK_W = 5 + LENGTH_BITS + VALUE_BITS + 1;

    typedef struct packed {
        logic [4:0]             code;
        logic [LENGTH_BITS-1:0] len;
        logic [VALUE_BITS-1:0]  val;
        logic                   ovf;
    } t_tok;

    logic                   accept;
    logic                   can_load;
    t_load                  load;
    logic [2:0][TOK_W-1:0]  toks;
    logic [TOK_W-1:0]       head_bits;
    t_tok                   head;

    // input handshake
    assign o_stall = !can_load;
    assign accept  = i_valid && can_load;

    // scanner
    kol_scan #(
        .VALUE_BITS  (VALUE_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .TOK_W       (TOK_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_is_final  (i_is_final),
        .o_load      (load),
        .o_tok       (toks)
    );

    // result queue
    kol_outq #(
        .W (TOK_W)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_data     (toks),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (head_bits),
        .o_last     (o_run_last)
    );

    // token fields
    assign head              = t_tok'(head_bits);
    assign o_token_code      = head.code;
    assign o_lexeme_length   = head.len;
    assign o_number_value    = head.val;
    assign o_number_overflow = head.ovf;

endmodule

// ===== tb/kol_checker.sv =====
// token predictor and scoreboard for the keyword and operator lexer
module kol_checker
    import kol_pkg::*;
#(
    parameter int VALUE_BITS  = 32,
    parameter int LENGTH_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [7:0]             i_char_code,
    input  logic                   i_is_final,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [4:0]             i_token_code,
    input  logic [LENGTH_BITS-1:0] i_lexeme_length,
    input  logic [VALUE_BITS-1:0]  i_number_value,
    input  logic                   i_number_overflow,
    input  logic                   i_run_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_token_count,
    output int                     o_keyword_count,
    output int                     o_overflow_count,
    output int                     o_max_length
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0]            VALUE_MAX  = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    typedef struct packed {
        logic [4:0]             code;
        logic [LENGTH_BITS-1:0] len;
        logic [VALUE_BITS-1:0]  value;
        logic                   ovf;
        logic                   last;
    } t_token;

    string kw_spell [9] = '{"Const", "Var", "if", "then", "else", "while", "do", "begin", "end"};

    // scanner state of the predictor
    t_mode                  scan_mode;
    logic [7:0]             word_head [PREFIX_LEN];
    logic [LENGTH_BITS-1:0] word_len;
    logic [63:0]            num_acc;
    logic                   num_sat;

    // tokens of the item being predicted, and all tokens still awaited
    t_token step_tokens [$];
    t_token token_q [$];

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_plus_one(logic [LENGTH_BITS-1:0] l);
        return (l < LENGTH_MAX) ? l + 1'b1 : LENGTH_MAX;
    endfunction

    // keyword lookup over the stored head of the word
    function automatic logic [4:0] word_code();
        bit same;
        for (int k = 0; k < 9; k++) begin
            same = (word_len == LENGTH_BITS'(kw_spell[k].len()));
            for (int j = 0; j < kw_spell[k].len(); j++) begin
                if (same && word_head[j] != kw_spell[k][j]) same = 1'b0;
            end
            if (same) return TOK_KW_FIRST + 5'(k);
        end
        return TOK_IDENT;
    endfunction

    task automatic add_token(logic [4:0] code, logic [LENGTH_BITS-1:0] len,
                             logic [VALUE_BITS-1:0] value, logic ovf);
        t_token t;
        t.code  = code;
        t.len   = len;
        t.value = value;
        t.ovf   = ovf;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic clear_scan();
        scan_mode = MODE_IDLE;
        for (int j = 0; j < PREFIX_LEN; j++) word_head[j] = 8'h00;
        word_len = '0;
        num_acc  = '0;
        num_sat  = 1'b0;
    endtask

    // decimal accumulate with saturation
    task automatic take_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_0);
        if (num_acc > (VALUE_MAX - d) / 10) begin
            num_acc = VALUE_MAX;
            num_sat = 1'b1;
        end else begin
            num_acc = num_acc * 10 + d;
        end
        word_len = len_plus_one(word_len);
    endtask

    // emit whatever token is still open
    task automatic close_token();
        case (scan_mode)
            MODE_IDENT: add_token(word_code(), word_len, '0, 1'b0);
            MODE_NUM:   add_token(TOK_NUMBER, word_len, num_acc[VALUE_BITS-1:0], num_sat);
            MODE_GT:    add_token(TOK_GT, 1, '0, 1'b0);
            MODE_LT:    add_token(TOK_LT, 1, '0, 1'b0);
            MODE_EQ:    add_token(TOK_EQ, 1, '0, 1'b0);
            default: ;
        endcase
        scan_mode = MODE_IDLE;
    endtask

    // a character seen from the idle mode
    task automatic open_token(logic [7:0] c);
        if (c == CH_SPACE || c == CH_NL) return;
        if (is_alpha(c)) begin
            scan_mode    = MODE_IDENT;
            word_head[0] = c;
            word_len     = 1;
        end else if (is_num(c)) begin
            scan_mode = MODE_NUM;
            num_acc   = '0;
            num_sat   = 1'b0;
            word_len  = '0;
            take_digit(c);
        end else begin
            case (c)
                CH_GT:     scan_mode = MODE_GT;
                CH_LT:     scan_mode = MODE_LT;
                CH_EQ:     scan_mode = MODE_EQ;
                CH_COMMA:  add_token(TOK_COMMA, 1, '0, 1'b0);
                CH_SEMI:   add_token(TOK_SEMI, 1, '0, 1'b0);
                CH_LPAREN: add_token(TOK_LPAREN, 1, '0, 1'b0);
                CH_RPAREN: add_token(TOK_RPAREN, 1, '0, 1'b0);
                CH_PLUS:   add_token(TOK_PLUS, 1, '0, 1'b0);
                CH_MINUS:  add_token(TOK_MINUS, 1, '0, 1'b0);
                CH_STAR:   add_token(TOK_STAR, 1, '0, 1'b0);
                CH_SLASH:  add_token(TOK_SLASH, 1, '0, 1'b0);
                default:   add_token(TOK_INVALID, 1, '0, 1'b0);
            endcase
        end
    endtask

    // predict the tokens of one accepted character
    task automatic scan_char(logic [7:0] c, logic fin);
        bit taken;
        taken = 1'b0;
        step_tokens.delete();
        case (scan_mode)
            MODE_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    if (word_len < PREFIX_LEN) word_head[word_len] = c;
                    word_len = len_plus_one(word_len);
                    taken = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_num(c)) begin
                    take_digit(c);
                    taken = 1'b1;
                end
            end
            MODE_GT: begin
                if (c == CH_EQ) begin
                    add_token(TOK_GE, 2, '0, 1'b0);
                    taken = 1'b1;
                end
            end
            MODE_LT: begin
                if (c == CH_EQ) begin
                    add_token(TOK_LE, 2, '0, 1'b0);
                    taken = 1'b1;
                end else if (c == CH_GT) begin
                    add_token(TOK_NE, 2, '0, 1'b0);
                    taken = 1'b1;
                end
            end
            MODE_EQ: begin
                if (c == CH_EQ) begin
                    add_token(TOK_EQEQ, 2, '0, 1'b0);
                    taken = 1'b1;
                end
            end
            default: ;
        endcase
        if (taken && scan_mode != MODE_IDENT && scan_mode != MODE_NUM) scan_mode = MODE_IDLE;
        if (!taken) begin
            close_token();
            open_token(c);
        end
        if (fin) begin
            close_token();
            add_token(TOK_END, 0, '0, 1'b0);
            clear_scan();
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    endtask

    // compare one delivered token with the oldest prediction
    task automatic check_token();
        t_token got;
        t_token want;
        got.code  = i_token_code;
        got.len   = i_lexeme_length;
        got.value = i_number_value;
        got.ovf   = i_number_overflow;
        got.last  = i_run_last;
        o_token_count++;
        if (token_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected token code=%0d len=%0d value=%0d ovf=%0b last=%0b",
                         $realtime, got.code, got.len, got.value, got.ovf, got.last);
            return;
        end
        want = token_q.pop_front();
        if (want.code >= TOK_KW_FIRST && want.code < TOK_IDENT) o_keyword_count++;
        if (want.ovf) o_overflow_count++;
        if (int'(want.len) > o_max_length) o_max_length = int'(want.len);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: token %0d wrong", $realtime, o_token_count);
                $display("  expected code=%0d len=%0d value=%0d ovf=%0b last=%0b",
                         want.code, want.len, want.value, want.ovf, want.last);
                $display("  actual   code=%0d len=%0d value=%0d ovf=%0b last=%0b",
                         got.code, got.len, got.value, got.ovf, got.last);
            end
        end
    endtask

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_token_count    = 0;
        o_keyword_count  = 0;
        o_overflow_count = 0;
        o_max_length     = 0;
        clear_scan();
    end

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            token_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_token();
            if (i_in_valid && !i_in_stall) scan_char(i_char_code, i_is_final);
        end
        o_pending = token_q.size();
    end

endmodule

// ===== tb/tb_keyword_operator_lexer.sv =====
// stimulus, watchdog and verdict for the keyword and operator lexer
module tb_keyword_operator_lexer;
    import kol_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 120;
    localparam int STUCK_LIMIT  = 2000;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic [7:0]  i_char_code       = 8'h00;
    logic        i_is_final        = 1'b0;
    logic        i_stall           = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_token_code;
    logic [7:0]  o_lexeme_length;
    logic [31:0] o_number_value;
    logic        o_number_overflow;
    logic        o_run_last;

    int fail_count;
    int pending;
    int token_count;
    int keyword_count;
    int overflow_count;
    int max_length;

    int chars_sent  = 0;
    int runs_closed = 0;
    int stuck       = 0;
    int tx_calm     = 0;
    int rx_calm     = 0;
    int rx_hold     = 0;

    logic [7:0] char_buf [$];

    string kw_words [9] = '{"Const", "Var", "if", "then", "else", "while", "do", "begin", "end"};
    string op_words [7] = '{">=", "<=", "<>", "==", ">", "<", "="};
    string punct    = ",;()+-*/";

    keyword_operator_lexer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_char_code       (i_char_code),
        .i_is_final        (i_is_final),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_token_code      (o_token_code),
        .o_lexeme_length   (o_lexeme_length),
        .o_number_value    (o_number_value),
        .o_number_overflow (o_number_overflow),
        .o_run_last        (o_run_last)
    );

    kol_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_char_code       (i_char_code),
        .i_is_final        (i_is_final),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_token_code      (o_token_code),
        .i_lexeme_length   (o_lexeme_length),
        .i_number_value    (o_number_value),
        .i_number_overflow (o_number_overflow),
        .i_run_last        (o_run_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_token_count     (token_count),
        .o_keyword_count   (keyword_count),
        .o_overflow_count  (overflow_count),
        .o_max_length      (max_length)
    );

    always #5 i_clk = ~i_clk;

    // no progress on either channel for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("no item moved for %0d cycles", STUCK_LIMIT);
            $display("keyword_operator_lexer: mismatch");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // receiver back-pressure: mostly no stall or short stalls, some long, some calm stretches
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else if (rx_calm > 0) begin
            rx_calm <= rx_calm - 1;
            i_stall <= 1'b0;
        end else if (r < 60) begin
            i_stall <= 1'b0;
        end else if (r < 66) begin
            rx_calm <= $urandom_range(20, 60);
            i_stall <= 1'b0;
        end else if (r < 93) begin
            rx_hold <= $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            rx_hold <= $urandom_range(10, 40);
            i_stall <= 1'b1;
        end
    end

    // idle cycles before the next item
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        if (r < 3) tx_calm = $urandom_range(20, 60);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // present one character and hold it until accepted; entered and left at a falling edge
    task automatic send_char(logic [7:0] c, logic fin);
        int gap;
        gap = tx_gap();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_is_final  <= fin;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        if (fin) runs_closed++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CH_LA + 8'(r) : CH_UA + 8'(r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
    endtask

    // send the buffered characters, marking a last character now and then
    task automatic flush_chars(bit may_end);
        logic [7:0] c;
        while (char_buf.size() > 0) begin
            c = char_buf.pop_front();
            send_char(c, may_end && ($urandom_range(0, 39) == 0));
        end
    endtask

    initial begin
        int kind;
        int n;
        int r;
        string w;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every operator and punctuation, odd bytes, last-character flushes
        add_text(">=<=<>==>,<;=()+-*/");
        char_buf.push_back(8'h00);
        char_buf.push_back(8'hFF);
        char_buf.push_back(8'h09);
        flush_chars(1'b0);
        send_char(CH_LT, 1'b1);
        send_char(CH_LA, 1'b0);
        send_char(CH_COMMA, 1'b1);

        // one identifier long enough to saturate the length
        add_text("begin");
        repeat (251) char_buf.push_back($urandom_range(0, 3) == 0 ? rand_digit() : rand_letter());
        char_buf.push_back(CH_SPACE);
        flush_chars(1'b0);

        // random token streams with occasional noise
        n = chars_sent;
        while (chars_sent - n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                w = kw_words[$urandom_range(0, 8)];
                r = $urandom_range(0, 7);
                if (r == 0) w = w.substr(0, w.len() - 2);
                add_text(w);
                if (r == 1) char_buf.push_back(rand_letter());
                if (r == 2) char_buf.push_back(rand_digit());
            end else if (kind < 40) begin
                char_buf.push_back(rand_letter());
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 11) : $urandom_range(0, 5);
                repeat (r) char_buf.push_back($urandom_range(0, 2) == 0 ? rand_digit()
                                                                        : rand_letter());
            end else if (kind < 60) begin
                r = $urandom_range(0, 7);
                if (r == 0) add_text("4294967295");
                else if (r == 1) add_text("4294967296");
                else if (r == 2) add_text("429496729");
                else if (r == 3) repeat ($urandom_range(11, 14)) char_buf.push_back(rand_digit());
                else repeat ($urandom_range(1, 10)) char_buf.push_back(rand_digit());
            end else if (kind < 80) begin
                add_text(op_words[$urandom_range(0, 6)]);
            end else if (kind < 90) begin
                char_buf.push_back(punct[$urandom_range(0, punct.len() - 1)]);
            end else begin
                char_buf.push_back(8'($urandom_range(0, 255)));
            end
            r = $urandom_range(0, 99);
            if (r < 50) char_buf.push_back(CH_SPACE);
            else if (r < 65) char_buf.push_back(CH_NL);
            flush_chars(1'b1);
        end
        send_char(CH_SPACE, 1'b1);
        i_valid <= 1'b0;

        // drain, then give the block a few more cycles
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("sent %0d characters in %0d closed runs; %0d tokens compared",
                 chars_sent, runs_closed, token_count);
        $display("%0d keywords, %0d saturated numbers, longest lexeme %0d",
                 keyword_count, overflow_count, max_length);
        if (fail_count == 0 && pending == 0) begin
            $display("keyword_operator_lexer: match");
        end else begin
            $display("keyword_operator_lexer: mismatch");
        end
        $finish;
    end

endmodule
